/* hdl/ic3_pkg.sv */
// Shared types, constants and helper functions for the 3x3 image convolution.
// No dependencies; every other file of the block refers to this package.
package ic3_pkg;

  localparam int PIX_W      = 8;
  localparam int COEFF_BITS = 8;
  localparam int TAPS       = 3;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_REG_W  = TAPS * COEFF_BITS;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int SUM_W      = 20;
  localparam int PROD_W     = PIX_W + COEFF_BITS + 1;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;
  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [WIDTH_W-1:0]   IMAGE_WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0]  IMAGE_HEIGHT_RESET = 13'd480;
  // Laplacian-style default: 1 1 1 / 1 -8 1 / 1 1 1
  localparam logic [ROW_REG_W-1:0] COEFF_OUTER_RESET  = 24'h010101;
  localparam logic [ROW_REG_W-1:0] COEFF_CENTER_RESET = 24'h01F801;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COEFF_TOP    = 3'd2,
    REG_COEFF_MIDDLE = 3'd3,
    REG_COEFF_BOTTOM = 3'd4
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // neighborhood indexed [row][column], row 0 oldest line, column 0 oldest column
  typedef logic [TAPS-1:0][TAPS-1:0][PIX_W-1:0] nbhd_t;
  typedef logic [TAPS-1:0][ROW_REG_W-1:0] coeff_rows_t;

  typedef struct packed {
    pixel_t upper;
    pixel_t lower;
  } line_pair_t;

  typedef struct packed {
    logic             emit;
    logic             frame_end;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_t;

  function automatic prod_t tap_mul(input logic [ROW_REG_W-1:0] row_taps,
                                    input int unsigned idx, input pixel_t px);
    logic [COEFF_BITS-1:0] raw;
    prod_t k;
    prod_t p;
    raw = row_taps[idx*COEFF_BITS +: COEFF_BITS];
    k = {{(PROD_W-COEFF_BITS){raw[COEFF_BITS-1]}}, raw};
    p = {{(PROD_W-PIX_W){1'b0}}, px};
    return k * p;
  endfunction

  function automatic pixel_t saturate(input sum_t s);
    pixel_t r;
    if (s[SUM_W-1]) begin
      r = '0;
    end else if (|s[SUM_W-2:PIX_W]) begin
      r = '1;
    end else begin
      r = s[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/ic3_pixel_if.sv */
// Input channel of the convolution: one gray pixel per beat.
// Depends on ic3_pkg.
interface ic3_pixel_if;
  logic            valid;
  logic            ready;
  ic3_pkg::pixel_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

/* hdl/ic3_result_if.sv */
// Output channel of the convolution: one interior result per beat.
// Depends on ic3_pkg.
interface ic3_result_if;
  logic                            valid;
  logic                            ready;
  ic3_pkg::sum_t                   conv_sum;
  ic3_pkg::pixel_t                 out_pixel;
  logic [ic3_pkg::ROW_W-1:0]       out_row;
  logic [ic3_pkg::COL_W-1:0]       out_col;
  logic                            frame_end;

  modport source (output valid, output conv_sum, output out_pixel, output out_row,
                  output out_col, output frame_end, input ready);
  modport sink (input valid, input conv_sum, input out_pixel, input out_row,
                input out_col, input frame_end, output ready);
endinterface

/* hdl/ic3_scan.sv */
// Raster position counters: column/row tracking, interior and frame-end flags.
// Depends on ic3_pkg.
module ic3_scan #(
  parameter int MAX_WIDTH = 1024,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [ic3_pkg::WIDTH_W-1:0]     image_width,
  input  logic [ic3_pkg::HEIGHT_W-1:0]    image_height,
  output logic [AW-1:0]                   addr,
  output ic3_pkg::pos_t                   pos
);

  localparam int WLW = (AW + 1 > ic3_pkg::WIDTH_W) ? AW + 1 : ic3_pkg::WIDTH_W;

  logic [AW-1:0]                col_count;
  logic [ic3_pkg::ROW_W-1:0]    row_count;
  logic [WLW-1:0]               width_ext;
  logic [WLW-1:0]               col_ext;
  logic [WLW-1:0]               col_prev;
  logic [WLW-1:0]               w_last;
  logic [ic3_pkg::HEIGHT_W-1:0] h_last;
  logic                         col_last;
  logic                         row_last;

  assign width_ext = WLW'(image_width);
  assign col_ext   = WLW'(col_count);
  assign col_prev  = col_ext - 1'b1;

  always_comb begin
    if (width_ext < WLW'(ic3_pkg::MIN_DIM)) begin
      w_last = WLW'(ic3_pkg::MIN_DIM - 1);
    end else if (width_ext > WLW'(MAX_WIDTH)) begin
      w_last = WLW'(MAX_WIDTH - 1);
    end else begin
      w_last = width_ext - 1'b1;
    end
    if (image_height < ic3_pkg::HEIGHT_W'(ic3_pkg::MIN_DIM)) begin
      h_last = ic3_pkg::HEIGHT_W'(ic3_pkg::MIN_DIM - 1);
    end else if (image_height > ic3_pkg::HEIGHT_W'(ic3_pkg::MAX_HEIGHT)) begin
      h_last = ic3_pkg::HEIGHT_W'(ic3_pkg::MAX_HEIGHT - 1);
    end else begin
      h_last = image_height - 1'b1;
    end
  end

  assign col_last = col_ext >= w_last;
  assign row_last = {1'b0, row_count} >= h_last;

  assign addr          = col_count;
  assign pos.emit      = (row_count >= ic3_pkg::ROW_W'(2)) && (col_count >= AW'(2));
  assign pos.frame_end = row_last && col_last;
  assign pos.row       = row_count - 1'b1;
  assign pos.col       = col_prev[ic3_pkg::COL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (step) begin
      if (col_last) begin
        col_count <= '0;
        row_count <= row_last ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

endmodule

/* hdl/ic3_line_buffer.sv */
// Two-line pixel store packed as one memory word per column, registered read.
// Depends on ic3_pkg.
module ic3_line_buffer #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output ic3_pkg::line_pair_t rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  ic3_pkg::line_pair_t wr_data
);

  ic3_pkg::line_pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/ic3_mac.sv */
// Nine-tap multiply and adder tree with saturation, three register stages.
// Depends on ic3_pkg.
module ic3_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  ic3_pkg::pos_t        in_pos,
  input  ic3_pkg::nbhd_t       nb,
  input  ic3_pkg::coeff_rows_t coeff,
  output logic                 out_valid,
  output ic3_pkg::sum_t        out_sum,
  output ic3_pkg::pixel_t      out_pixel,
  output ic3_pkg::pos_t        out_pos
);

  localparam int T = ic3_pkg::TAPS;

  ic3_pkg::prod_t prod   [T][T];
  ic3_pkg::prod_t prod_d [T][T];
  ic3_pkg::sum_t  rsum   [T];
  ic3_pkg::sum_t  rsum_d [T];
  ic3_pkg::sum_t  total_d;
  ic3_pkg::pos_t  s2_pos;
  ic3_pkg::pos_t  s3_pos;
  logic           s2_valid;
  logic           s3_valid;

  // flipped kernel: pixel (v,u) meets tap (2-v, 2-u)
  always_comb begin
    for (int v = 0; v < T; v++) begin
      for (int u = 0; u < T; u++) begin
        prod_d[v][u] = ic3_pkg::tap_mul(coeff[T-1-v], T-1-u, nb[v][u]);
      end
    end
    for (int v = 0; v < T; v++) begin
      rsum_d[v] = ic3_pkg::SUM_W'(prod[v][0]) + ic3_pkg::SUM_W'(prod[v][1])
                + ic3_pkg::SUM_W'(prod[v][2]);
    end
    total_d = rsum[0] + rsum[1] + rsum[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s2_valid  <= in_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod      <= prod_d;
      s2_pos    <= in_pos;
      rsum      <= rsum_d;
      s3_pos    <= s2_pos;
      out_sum   <= total_d;
      out_pixel <= ic3_pkg::saturate(total_d);
      out_pos   <= s3_pos;
    end
  end

`ifndef SYNTHESIS
  a_stall_holds_valid: assert property (@(posedge clk) disable iff (rst)
    !adv |=> out_valid)
    else $error("result pipeline lost a stalled beat");

  a_sat_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_sum[ic3_pkg::SUM_W-1] && (|out_sum[ic3_pkg::SUM_W-2:ic3_pkg::PIX_W])
    |-> out_pixel == '1)
    else $error("saturation high mismatch");

  a_sat_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_sum[ic3_pkg::SUM_W-1] |-> out_pixel == '0)
    else $error("saturation low mismatch");
`endif

endmodule

/* hdl/image_3x3_convolution.sv */
// Top level of the 3x3 image convolution: config registers, line store, window, result path.
// Depends on ic3_pkg, ic3_pixel_if, ic3_result_if, ic3_scan, ic3_line_buffer, ic3_mac.
//
// Takes one 8-bit pixel per clock in raster order and returns, for every interior
// position, the exact signed flipped-kernel sum, an 8-bit saturated copy, its row and
// column, and a frame-end mark. Throughput is one pixel per clock; a beat passes the input,
// product, row-sum and output registers before its result leaves. The limit is the line
// store, which serves one column read and one write-back per clock. Any stall on the result
// side holds the whole pipeline and drops ready on the pixel side in the same cycle. The
// line store has no clearing pass and needs no warm-up after reset. The user must write
// image size and kernel only while the block is idle; the block itself does not enforce it.
module image_3x3_convolution #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  ic3_pixel_if.sink                          pixels,
  ic3_result_if.source                       results,
  input  logic                               cfg_write,
  input  logic [ic3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ic3_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int T  = ic3_pkg::TAPS;

  logic [ic3_pkg::WIDTH_W-1:0]  image_width;
  logic [ic3_pkg::HEIGHT_W-1:0] image_height;
  ic3_pkg::coeff_rows_t         coeff_rows;

  logic                adv;
  logic                take;
  logic [AW-1:0]       rd_addr;
  ic3_pkg::pos_t       pos0;
  ic3_pkg::line_pair_t rd_q;
  ic3_pkg::line_pair_t wr_pair;
  logic                s1_valid;
  logic [AW-1:0]       s1_addr;
  ic3_pkg::pixel_t     s1_px;
  ic3_pkg::pos_t       s1_pos;
  ic3_pkg::pixel_t     win [2][T];
  ic3_pkg::pixel_t     col [T];
  ic3_pkg::nbhd_t      nb;
  ic3_pkg::pos_t       out_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= ic3_pkg::IMAGE_WIDTH_RESET;
      image_height  <= ic3_pkg::IMAGE_HEIGHT_RESET;
      coeff_rows[0] <= ic3_pkg::COEFF_OUTER_RESET;
      coeff_rows[1] <= ic3_pkg::COEFF_CENTER_RESET;
      coeff_rows[2] <= ic3_pkg::COEFF_OUTER_RESET;
    end else if (cfg_write) begin
      case (ic3_pkg::cfg_reg_t'(cfg_index))
        ic3_pkg::REG_IMAGE_WIDTH:  image_width   <= cfg_data[ic3_pkg::WIDTH_W-1:0];
        ic3_pkg::REG_IMAGE_HEIGHT: image_height  <= cfg_data[ic3_pkg::HEIGHT_W-1:0];
        ic3_pkg::REG_COEFF_TOP:    coeff_rows[0] <= cfg_data[ic3_pkg::ROW_REG_W-1:0];
        ic3_pkg::REG_COEFF_MIDDLE: coeff_rows[1] <= cfg_data[ic3_pkg::ROW_REG_W-1:0];
        ic3_pkg::REG_COEFF_BOTTOM: coeff_rows[2] <= cfg_data[ic3_pkg::ROW_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv          = !results.valid || results.ready;
  assign take         = pixels.valid && adv;
  assign pixels.ready = adv;

  ic3_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (take),
    .image_width  (image_width),
    .image_height (image_height),
    .addr         (rd_addr),
    .pos          (pos0)
  );

  // Consecutive beats always hit different columns, so the write-back of one
  // beat never collides with the read of the next.
  assign wr_pair.upper = rd_q.lower;
  assign wr_pair.lower = s1_px;

  ic3_line_buffer #(.DEPTH(MAX_WIDTH)) u_lines (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (rd_addr),
    .rd_data (rd_q),
    .wr_en   (s1_valid && adv),
    .wr_addr (s1_addr),
    .wr_data (wr_pair)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr <= rd_addr;
      s1_px   <= pixels.pixel;
      s1_pos  <= pos0;
    end
  end

  assign col[0] = rd_q.upper;
  assign col[1] = rd_q.lower;
  assign col[2] = s1_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        for (int v = 0; v < T; v++) begin
          win[i][v] <= '0;
        end
      end
    end else if (s1_valid && adv) begin
      for (int v = 0; v < T; v++) begin
        win[0][v] <= win[1][v];
        win[1][v] <= col[v];
      end
    end
  end

  always_comb begin
    for (int v = 0; v < T; v++) begin
      nb[v][0] = win[0][v];
      nb[v][1] = win[1][v];
      nb[v][2] = col[v];
    end
  end

  ic3_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s1_valid && s1_pos.emit),
    .in_pos    (s1_pos),
    .nb        (nb),
    .coeff     (coeff_rows),
    .out_valid (results.valid),
    .out_sum   (results.conv_sum),
    .out_pixel (results.out_pixel),
    .out_pos   (out_pos)
  );

  assign results.out_row   = out_pos.row;
  assign results.out_col   = out_pos.col;
  assign results.frame_end = out_pos.frame_end;

`ifndef SYNTHESIS
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |-> !pixels.ready)
    else $error("pixel beat taken while result stalled");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    s1_valid && take |-> s1_addr != rd_addr)
    else $error("line store read and write-back on the same column");

  a_emit_only_interior: assert property (@(posedge clk) disable iff (rst)
    take && pos0.emit |=> s1_valid && s1_pos.emit)
    else $error("interior beat lost before the multiply stage");
`endif

endmodule
